### hw/rtl/irle_pkg.sv
`default_nettype none
package irle_pkg;

  localparam int unsigned MAX_RUN_DEF = 127;
  localparam int unsigned MAX_WIDTH   = 8190;

  localparam int unsigned CFG_DW = 13;
  localparam int unsigned CFG_IW = 2;

  localparam logic        STORAGE_MODE_RST  = 1'b0;
  localparam logic [12:0] ROW_WIDTH_RST     = 13'd500;
  localparam logic [12:0] ROW_COUNT_RST     = 13'd500;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;

  localparam logic [7:0] BYTE_LONE    = 8'h81;
  localparam logic [7:0] BYTE_ROW_END = 8'h80;

  typedef enum logic [1:0] {
    CFG_MODE,
    CFG_WIDTH,
    CFG_ROWS,
    CFG_CHANS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VERB,
    ST_HEAD,
    ST_ONE,
    ST_LIT,
    ST_RELOAD,
    ST_TAIL
  } state_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_PEND,
    SEL_HEAD,
    SEL_FIRST,
    SEL_MEM,
    SEL_TAIL
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    byte_sel_t sel;
    logic      flush_last;
    logic      step_end;
    logic      row_end;
    logic      reload;
  } ctl_cmd_t;

  typedef struct packed {
    logic mode;
    logic brk;
    logic last;
    logic one_byte;
    logic lit_end;
    logic push_ok;
  } dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/irle_pix_if.sv
`default_nettype none
interface irle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

### hw/rtl/irle_word_if.sv
`default_nettype none
interface irle_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;
  logic [3:0]  byte_count;
  logic        row_done;
  logic [13:0] row_length;
  logic [14:0] table_index;

  modport source (output valid, output data_bytes, output byte_count, output row_done,
                  output row_length, output table_index, input ready);
  modport sink   (input valid, input data_bytes, input byte_count, input row_done,
                  input row_length, input table_index, output ready);
endinterface
`default_nettype wire

### hw/rtl/image_row_rle_encoder.sv
// channel   dir  handshake          payload
// pixels    in   valid/ready        pixel[7:0]
// codes     out  valid/ready        data_bytes[63:0] byte_count[3:0] row_done
//                                   row_length[13:0] table_index[14:0]
// cfg       in   cfg_we (no ready)  cfg_index[1:0] cfg_data[12:0]
//
// A pixel that only extends a run is taken in the idle state; a verbatim pixel also passes the verbatim state.
// A run ends with a header byte plus one byte (repeat, lone) or plus n pixels read
// from the run store one entry per cycle unless held; every break adds a reload
// state, and a break at row end also adds a lone-pixel pair. A run-length row ends
// with 0x80. The byte sequencer moves one byte per cycle when it is not held.
// Reset is synchronous and restores the configuration registers and the counters; the run store needs
// no clearing. A full output register with ready low holds the byte sequencer on a byte that ends a word.
`default_nettype none
module image_row_rle_encoder #(
  parameter int unsigned MAX_RUN = irle_pkg::MAX_RUN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  irle_pix_if.sink                     pixels,
  irle_word_if.source                  codes,
  input  logic                         cfg_we,
  input  logic [irle_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [irle_pkg::CFG_DW-1:0]  cfg_data
);

  irle_pkg::ctl_cmd_t   cmd;
  irle_pkg::dp_status_t sts;
  logic                 in_ready;

  irle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign pixels.ready = in_ready;

  irle_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixels.pixel),
    .cmd       (cmd),
    .sts       (sts),
    .codes     (codes)
  );

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    codes.valid |-> (codes.byte_count != 4'd0 && codes.byte_count <= 4'd8))
    else $error("byte_count out of range");

  a_row_side: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && !codes.row_done) |-> (codes.row_length == 14'd0 &&
                                          codes.table_index == 15'd0))
    else $error("row fields set without row_done");

  a_reload_lone: assert property (@(posedge clk) disable iff (rst)
    cmd.reload |=> sts.one_byte)
    else $error("reloaded run is not a single pixel");

endmodule
`default_nettype wire

### hw/rtl/irle_ctrl.sv
`default_nettype none
module irle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  irle_pkg::dp_status_t  sts,
  output irle_pkg::ctl_cmd_t    cmd
);

  irle_pkg::state_t state;
  irle_pkg::state_t state_next;
  irle_pkg::state_t after_flush;
  logic             last_q;
  logic             reload_pend;

  always_comb begin
    if (reload_pend) begin
      after_flush = irle_pkg::ST_RELOAD;
    end else if (last_q) begin
      after_flush = irle_pkg::ST_TAIL;
    end else begin
      after_flush = irle_pkg::ST_IDLE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      irle_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!sts.mode) begin
            state_next = irle_pkg::ST_VERB;
          end else if (sts.brk || sts.last) begin
            state_next = irle_pkg::ST_HEAD;
          end
        end
      end
      irle_pkg::ST_VERB: begin
        if (sts.push_ok) state_next = irle_pkg::ST_IDLE;
      end
      irle_pkg::ST_HEAD: begin
        if (sts.push_ok) begin
          state_next = sts.one_byte ? irle_pkg::ST_ONE : irle_pkg::ST_LIT;
        end
      end
      irle_pkg::ST_ONE: begin
        if (sts.push_ok) state_next = after_flush;
      end
      irle_pkg::ST_LIT: begin
        if (sts.push_ok && sts.lit_end) state_next = after_flush;
      end
      irle_pkg::ST_RELOAD: begin
        state_next = last_q ? irle_pkg::ST_HEAD : irle_pkg::ST_IDLE;
      end
      irle_pkg::ST_TAIL: begin
        if (sts.push_ok) state_next = irle_pkg::ST_IDLE;
      end
      default: state_next = irle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.sel        = irle_pkg::SEL_NONE;
    unique case (state)
      irle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      irle_pkg::ST_VERB: begin
        cmd.sel      = irle_pkg::SEL_PEND;
        cmd.step_end = 1'b1;
      end
      irle_pkg::ST_HEAD: begin
        cmd.sel = irle_pkg::SEL_HEAD;
      end
      irle_pkg::ST_ONE: begin
        cmd.sel        = irle_pkg::SEL_FIRST;
        cmd.flush_last = 1'b1;
        cmd.step_end   = !last_q;
      end
      irle_pkg::ST_LIT: begin
        cmd.sel        = irle_pkg::SEL_MEM;
        cmd.flush_last = sts.lit_end;
        cmd.step_end   = sts.lit_end && !last_q;
      end
      irle_pkg::ST_RELOAD: begin
        cmd.reload = 1'b1;
      end
      irle_pkg::ST_TAIL: begin
        cmd.sel      = irle_pkg::SEL_TAIL;
        cmd.step_end = 1'b1;
      end
      default: begin
        cmd.sel = irle_pkg::SEL_NONE;
      end
    endcase
    cmd.row_end = cmd.step_end && last_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= irle_pkg::ST_IDLE;
      last_q      <= 1'b0;
      reload_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        last_q      <= sts.last;
        reload_pend <= sts.brk;
      end
      if (cmd.reload) begin
        reload_pend <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/irle_dp.sv
`default_nettype none
module irle_dp #(
  parameter int unsigned MAX_RUN = irle_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [irle_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [irle_pkg::CFG_DW-1:0]   cfg_data,
  input  logic [7:0]                    pixel,
  input  irle_pkg::ctl_cmd_t            cmd,
  output irle_pkg::dp_status_t          sts,
  irle_word_if.source                   codes
);

  localparam int unsigned LW = $clog2(MAX_RUN + 1);
  localparam int unsigned AW = $clog2(MAX_RUN);

  logic        storage_mode;
  logic [12:0] row_width;
  logic [12:0] row_count;
  logic [2:0]  channel_count;

  logic [12:0] column_counter;
  logic [12:0] row_counter;
  logic [1:0]  channel_counter;
  logic [13:0] row_byte_total;
  logic [LW-1:0] run_length;
  logic        run_is_repeat;

  logic [7:0]  run_store [MAX_RUN];
  logic [7:0]  rd_data;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_next;
  logic [7:0]  first_px;
  logic [7:0]  pend;
  logic [14:0] tidx;

  logic [63:0] acc;
  logic [2:0]  cnt;

  logic [12:0] width_eff;
  logic [13:0] col_inc;
  logic [13:0] row_inc;
  logic [2:0]  chan_inc;
  logic [2:0]  chans;
  logic        row_wrap;
  logic        chan_wrap;
  logic        last;
  logic        eq;
  logic        can_ext;
  logic        brk;
  logic [14:0] tidx_calc;

  logic [7:0]  byte_val;
  logic        word_full;
  logic        out_free;
  logic        push_ok;
  logic        push_en;
  logic [63:0] word_val;
  logic        lit_end;

  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]  mem_wdata;

  assign width_eff = (row_width > 13'(irle_pkg::MAX_WIDTH)) ? 13'(irle_pkg::MAX_WIDTH)
                                                             : row_width;
  assign col_inc   = {1'b0, column_counter} + 14'd1;
  assign last      = col_inc >= {1'b0, width_eff};
  assign row_inc   = {1'b0, row_counter} + 14'd1;
  assign row_wrap  = row_inc >= {1'b0, row_count};
  assign chan_inc  = {1'b0, channel_counter} + 3'd1;
  assign chans     = (channel_count == 3'd0) ? 3'd1 :
                     ((channel_count > 3'd4) ? 3'd4 : channel_count);
  assign chan_wrap = chan_inc >= chans;
  assign tidx_calc = 15'(row_counter) + 15'(row_count) * 15'(channel_counter);

  assign eq      = pixel == first_px;
  assign can_ext = (run_length < LW'(MAX_RUN)) && (eq == run_is_repeat);
  assign brk     = storage_mode && (run_length >= LW'(2)) && !can_ext;
  assign lit_end = LW'(ptr) == (run_length - LW'(1));

  always_comb begin
    unique case (cmd.sel)
      irle_pkg::SEL_PEND:  byte_val = pend;
      irle_pkg::SEL_HEAD: begin
        if (run_length == LW'(1)) begin
          byte_val = irle_pkg::BYTE_LONE;
        end else begin
          byte_val = {~run_is_repeat, 7'(run_length)};
        end
      end
      irle_pkg::SEL_FIRST: byte_val = first_px;
      irle_pkg::SEL_MEM:   byte_val = rd_data;
      irle_pkg::SEL_TAIL:  byte_val = irle_pkg::BYTE_ROW_END;
      default:             byte_val = 8'h00;
    endcase
  end

  assign word_full = (cnt == 3'd7) || cmd.step_end;
  assign out_free  = !codes.valid || codes.ready;
  assign push_ok   = !word_full || out_free;
  assign push_en   = (cmd.sel != irle_pkg::SEL_NONE) && push_ok;
  assign word_val  = acc | (64'(byte_val) << {cnt, 3'b000});

  always_comb begin
    if (cmd.sel != irle_pkg::SEL_MEM) begin
      ptr_next = '0;
    end else if (push_en && lit_end) begin
      ptr_next = '0;
    end else if (push_en) begin
      ptr_next = ptr + AW'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign mem_we    = (cmd.load && storage_mode && !brk) || cmd.reload;
  assign mem_addr  = cmd.reload ? '0 : run_length[AW-1:0];
  assign mem_wdata = cmd.reload ? pend : pixel;

  always_comb begin
    sts.mode     = storage_mode;
    sts.brk      = brk;
    sts.last     = last;
    sts.one_byte = (run_length == LW'(1)) || run_is_repeat;
    sts.lit_end  = lit_end;
    sts.push_ok  = push_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      storage_mode    <= irle_pkg::STORAGE_MODE_RST;
      row_width       <= irle_pkg::ROW_WIDTH_RST;
      row_count       <= irle_pkg::ROW_COUNT_RST;
      channel_count   <= irle_pkg::CHANNEL_COUNT_RST;
      column_counter  <= '0;
      row_counter     <= '0;
      channel_counter <= '0;
      row_byte_total  <= '0;
      run_length      <= '0;
      run_is_repeat   <= 1'b0;
      ptr             <= '0;
      acc             <= '0;
      cnt             <= '0;
      codes.valid     <= 1'b0;
    end else begin
      ptr <= ptr_next;

      if (cfg_we) begin
        unique case (irle_pkg::cfg_reg_t'(cfg_index))
          irle_pkg::CFG_MODE:  storage_mode  <= cfg_data[0];
          irle_pkg::CFG_WIDTH: row_width     <= cfg_data[12:0];
          irle_pkg::CFG_ROWS:  row_count     <= cfg_data[12:0];
          irle_pkg::CFG_CHANS: channel_count <= cfg_data[2:0];
        endcase
      end

      if (cmd.load) begin
        if (last) begin
          column_counter <= '0;
          if (row_wrap) begin
            row_counter     <= '0;
            channel_counter <= chan_wrap ? 2'd0 : chan_inc[1:0];
          end else begin
            row_counter <= row_inc[12:0];
          end
        end else begin
          column_counter <= col_inc[12:0];
        end
        if (!storage_mode) begin
          run_length    <= '0;
          run_is_repeat <= 1'b0;
        end else if (!brk) begin
          if (run_length == LW'(1)) run_is_repeat <= eq;
          run_length <= run_length + LW'(1);
        end
      end

      if (push_en) begin
        row_byte_total <= cmd.row_end ? 14'd0 : row_byte_total + 14'd1;
        if (word_full) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= word_val;
          cnt <= cnt + 3'd1;
        end
        if (cmd.flush_last) begin
          run_length    <= '0;
          run_is_repeat <= 1'b0;
        end
      end

      if (cmd.reload) begin
        run_length    <= LW'(1);
        run_is_repeat <= 1'b0;
      end

      if (push_en && word_full) begin
        codes.valid <= 1'b1;
      end else if (codes.ready) begin
        codes.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_store[mem_addr] <= mem_wdata;
    end
    rd_data <= run_store[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend <= pixel;
      tidx <= tidx_calc;
      if (run_length == '0) first_px <= pixel;
    end
    if (cmd.reload) begin
      first_px <= pend;
    end
    if (push_en && word_full) begin
      codes.data_bytes  <= word_val;
      codes.byte_count  <= {1'b0, cnt} + 4'd1;
      codes.row_done    <= cmd.row_end;
      codes.row_length  <= cmd.row_end ? row_byte_total + 14'd1 : 14'd0;
      codes.table_index <= cmd.row_end ? tidx : 15'd0;
    end
  end

endmodule
`default_nettype wire
